// File: hdl/kmp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

  // Array size and price width
  localparam int MAX_PAIRS  = 16;
  localparam int PRICE_BITS = 16;

  // Fixed field widths
  localparam int K_BITS   = 5;
  localparam int OUT_BITS = 20;

  // Best profit after j pairs is below MAX_PAIRS * 2**PRICE_BITS
  localparam int SOLD_BITS = PRICE_BITS + $clog2(MAX_PAIRS);
  // Holding value is signed and one bit wider
  localparam int HOLD_BITS = SOLD_BITS + 1;
  // Select index covering 0..MAX_PAIRS
  localparam int IDX_BITS  = $clog2(MAX_PAIRS + 1);

  localparam logic [OUT_BITS-1:0]  OUT_MAX   = '1;
  // Most negative holding value marks an unreachable state
  localparam logic [HOLD_BITS-1:0] HOLD_NONE = {1'b1, {(HOLD_BITS-1){1'b0}}};

  typedef logic [SOLD_BITS-1:0]        sold_t;
  typedef logic signed [HOLD_BITS-1:0] hold_t;
  typedef logic [PRICE_BITS-1:0]       price_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic step;   // a price is transferred this cycle
    logic clear;  // that price closes the sequence
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/kmp_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One transaction count: best holding and best sold values
module kmp_cell import kmp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire price_t     price,
  input  wire sold_t      sold_left,   // previous sold value of the cell before
  output      sold_t      sold,        // registered sold value
  output      sold_t      sold_next    // value after this price
);

  hold_t                 hold;
  hold_t                 hold_next;
  hold_t                 buy;
  logic signed [HOLD_BITS:0] sell;

  // Buy from the left neighbour's sale, sell from own holding
  always_comb begin
    buy  = $signed({1'b0, sold_left})
         - $signed({{(HOLD_BITS-PRICE_BITS){1'b0}}, price});
    sell = $signed({hold[HOLD_BITS-1], hold})
         + $signed({{(HOLD_BITS+1-PRICE_BITS){1'b0}}, price});
    hold_next = (buy > hold) ? buy : hold;
    sold_next = (sell > $signed({2'b00, sold})) ? SOLD_BITS'(sell) : sold;
  end

  // State update, cleared at reset and after the last price
  always_ff @(posedge clk) begin
    if (rst || (ctrl.step && ctrl.clear)) begin
      hold <= HOLD_NONE;
      sold <= '0;
    end else if (ctrl.step) begin
      hold <= hold_next;
      sold <= sold_next;
    end
  end

endmodule

`default_nettype wire

// File: hdl/k_transaction_max_profit_top.sv
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------
// input     | in_valid / in_ready    | price[15:0], last_price
// output    | out_valid / out_ready  | best_profit[19:0]
// config    | cfg_we (no wait)       | cfg_data[4:0] = max_transactions
//
// Every cell updates in the same cycle, so one price is taken per cycle while in_ready is high.
// The result of a sequence is registered from its last price and valid in the next cycle.
// in_ready drops only while a result waits and out_ready is low.
// Synchronous reset: cells cleared, limit set to 1, no result pending.
// Cells clear themselves on the last price; the limit is kept.
`timescale 1ns / 1ps
`default_nettype none

module k_transaction_max_profit_top import kmp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [K_BITS-1:0]     cfg_data,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic [PRICE_BITS-1:0] price,
  input  wire logic                  last_price,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic [OUT_BITS-1:0]   best_profit
);

  logic [K_BITS-1:0] max_transactions;
  cell_ctrl_t        ctrl;
  logic              in_xfer;
  sold_t             sold_chain [MAX_PAIRS+1];
  sold_t             sold_upd   [MAX_PAIRS+1];
  logic [IDX_BITS-1:0] pick;
  sold_t             picked;
  logic [OUT_BITS-1:0] profit_sat;
  int                k_lim;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_transactions <= K_BITS'(1);
    end else if (cfg_we) begin
      max_transactions <= cfg_data;
    end
  end

  // Handshake and cell control
  assign in_ready   = !out_valid || out_ready;
  assign in_xfer    = in_valid && in_ready;
  assign ctrl.step  = in_xfer;
  assign ctrl.clear = last_price;

  // Zero transactions always give zero
  assign sold_chain[0] = '0;
  assign sold_upd[0]   = '0;

  // Row of cells, each fed by its left neighbour
  for (genvar j = 1; j <= MAX_PAIRS; j++) begin : g_cell
    kmp_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .price     (price),
      .sold_left (sold_chain[j-1]),
      .sold      (sold_chain[j]),
      .sold_next (sold_upd[j])
    );
  end

  // Pick the cell of the clamped limit and saturate to the output width
  always_comb begin
    k_lim  = int'(max_transactions);
    if (k_lim > MAX_PAIRS) begin
      k_lim = MAX_PAIRS;
    end
    pick   = IDX_BITS'(k_lim);
    picked = sold_upd[pick];
    if (64'(picked) > 64'(OUT_MAX)) begin
      profit_sat = OUT_MAX;
    end else begin
      profit_sat = OUT_BITS'(picked);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && last_price) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && last_price) begin
      best_profit <= profit_sat;
    end
  end

  // A closing price always leaves a result behind
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer && last_price |=> out_valid)
    else $error("closing price gave no result");

  // The first and last cells hold a sold value of zero after a closing price
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    in_xfer && last_price |=> sold_chain[1] == '0 && sold_chain[MAX_PAIRS] == '0)
    else $error("cells not cleared after closing price");

  // More allowed pairs never give less (the last cell is checked against the first)
  a_monotone: assert property (@(posedge clk) disable iff (rst)
    sold_chain[MAX_PAIRS] >= sold_chain[1])
    else $error("sold values not monotone along the row");

  // A result appears only after a closing price
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && last_price))
    else $error("result without closing price");

endmodule

`default_nettype wire
